// ===== rtl/oriented_rect_overlap_test_unit_defines.svh =====
// assertion helpers shared by the rtl files
// all checks are clocked on i_clk and ignored while i_rst_n is low
`ifndef ORIENTED_RECT_OVERLAP_TEST_UNIT_DEFINES_SVH
`define ORIENTED_RECT_OVERLAP_TEST_UNIT_DEFINES_SVH

// plain property check
`define ORTEST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same-cycle implication check
`define ORTEST_ASSERT_IMP(lbl, ante, cons, msg) \
    `ORTEST_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication check
`define ORTEST_ASSERT_NXT(lbl, ante, cons, msg) \
    `ORTEST_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/ortest_pkg.sv =====
`timescale 1ns / 1ps

package ortest_pkg;

    localparam int COORD_BITS = 24;
    localparam int N_EDGES    = 4;
    localparam int N_AXES     = 4;
    localparam int N_FIELDS   = 2 * N_EDGES + 2;
    localparam int N_PAIRS    = N_EDGES * (N_EDGES + 1) / 2;
    localparam int EDGE_W     = $clog2(N_EDGES);
    localparam int PAIR_W     = $clog2(N_PAIRS);

    // exact widths: product, dot product, doubled center term, sum of four
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int DOT_W  = PROD_W + 1;
    localparam int DIST_W = DOT_W + 1;
    localparam int SUM_W  = DOT_W + EDGE_W;

    localparam int IN_FIELDS_W  = N_FIELDS * COORD_BITS;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int AXIS_W       = 3;
    localparam int OUT_FIELDS_W = 1 + AXIS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [AXIS_W-1:0] t_axis;
    localparam t_axis AXIS_NONE = t_axis'(N_AXES);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord y;
        t_coord x;
    } t_vec;

    // edges[0] left a, [1] left b, [2] right a, [3] right b
    typedef struct packed {
        t_vec                cdiff;
        t_vec [N_EDGES-1:0]  edges;
    } t_item;

    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_prod y;
        t_prod x;
    } t_prod_pair;

    typedef struct packed {
        t_prod_pair [N_AXES-1:0]  ctr;
        t_prod_pair [N_PAIRS-1:0] edg;
    } t_prods;

    typedef logic [DOT_W-1:0]  t_mag;
    typedef logic [DIST_W-1:0] t_dist;

    typedef struct packed {
        t_dist [N_AXES-1:0]  dist2;
        t_mag  [N_PAIRS-1:0] edg;
    } t_mags;

    typedef logic [EDGE_W-1:0] t_edge_idx;
    typedef logic [PAIR_W-1:0] t_pair_idx;

    // edge dot products are symmetric, so only the upper triangle is formed
    localparam t_edge_idx PAIR_A [N_PAIRS] =
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
    localparam t_edge_idx PAIR_B [N_PAIRS] =
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
    localparam t_pair_idx PAIR_IDX [N_EDGES][N_EDGES] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3},
        '{4'd1, 4'd4, 4'd5, 4'd6},
        '{4'd2, 4'd5, 4'd7, 4'd8},
        '{4'd3, 4'd6, 4'd8, 4'd9}
    };

endpackage

// ===== rtl/ortest_mul.sv =====
`timescale 1ns / 1ps

// product stage: every coordinate product for one item, registered
module ortest_mul (
    input  logic               i_clk,
    input  logic               i_en,
    input  ortest_pkg::t_item  i_item,
    output ortest_pkg::t_prods o_prods
);

    ortest_pkg::t_prods n_prods;
    ortest_pkg::t_prods r_prods;

    always_comb begin
        for (int p = 0; p < ortest_pkg::N_PAIRS; p++) begin
            n_prods.edg[p].x = i_item.edges[ortest_pkg::PAIR_A[p]].x
                             * i_item.edges[ortest_pkg::PAIR_B[p]].x;
            n_prods.edg[p].y = i_item.edges[ortest_pkg::PAIR_A[p]].y
                             * i_item.edges[ortest_pkg::PAIR_B[p]].y;
        end
        for (int a = 0; a < ortest_pkg::N_AXES; a++) begin
            n_prods.ctr[a].x = i_item.cdiff.x * i_item.edges[a].x;
            n_prods.ctr[a].y = i_item.cdiff.y * i_item.edges[a].y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prods <= n_prods;
        end
    end

    assign o_prods = r_prods;

endmodule

// ===== rtl/ortest_abs.sv =====
`timescale 1ns / 1ps

// dot product magnitudes; center terms are doubled to drop the halving
module ortest_abs (
    input  logic               i_clk,
    input  logic               i_en,
    input  ortest_pkg::t_prods i_prods,
    output ortest_pkg::t_mags  o_mags
);

    ortest_pkg::t_mags n_mags;
    ortest_pkg::t_mags r_mags;

    function automatic ortest_pkg::t_mag abs_dot(input ortest_pkg::t_prod_pair pp);
        logic signed [ortest_pkg::DOT_W-1:0] dot;
        dot = ortest_pkg::DOT_W'($signed(pp.x)) + ortest_pkg::DOT_W'($signed(pp.y));
        return dot[ortest_pkg::DOT_W-1] ? ortest_pkg::t_mag'(-dot)
                                        : ortest_pkg::t_mag'(dot);
    endfunction

    always_comb begin
        for (int p = 0; p < ortest_pkg::N_PAIRS; p++) begin
            n_mags.edg[p] = abs_dot(i_prods.edg[p]);
        end
        for (int a = 0; a < ortest_pkg::N_AXES; a++) begin
            n_mags.dist2[a] = {abs_dot(i_prods.ctr[a]), 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mags <= n_mags;
        end
    end

    assign o_mags = r_mags;

endmodule

// ===== rtl/ortest_cmp.sv =====
`timescale 1ns / 1ps

// per-axis extent sum against center distance, then first separating axis
module ortest_cmp (
    input  logic              i_clk,
    input  logic              i_en,
    input  ortest_pkg::t_mags i_mags,
    output logic              o_overlap,
    output ortest_pkg::t_axis o_axis
);

    logic [ortest_pkg::N_AXES-1:0]  sep;
    logic [ortest_pkg::SUM_W-1:0]   sum [ortest_pkg::N_AXES];
    ortest_pkg::t_axis              n_axis;
    ortest_pkg::t_axis              r_axis;
    logic                           r_overlap;

    always_comb begin
        for (int a = 0; a < ortest_pkg::N_AXES; a++) begin
            sum[a] = '0;
            for (int e = 0; e < ortest_pkg::N_EDGES; e++) begin
                sum[a] = sum[a]
                       + ortest_pkg::SUM_W'(i_mags.edg[ortest_pkg::PAIR_IDX[a][e]]);
            end
            // touching is not a separation
            sep[a] = sum[a] < ortest_pkg::SUM_W'(i_mags.dist2[a]);
        end
        n_axis = ortest_pkg::AXIS_NONE;
        for (int a = ortest_pkg::N_AXES - 1; a >= 0; a--) begin
            if (sep[a]) begin
                n_axis = ortest_pkg::t_axis'(a);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axis    <= n_axis;
            r_overlap <= ~|sep;
        end
    end

    assign o_axis    = r_axis;
    assign o_overlap = r_overlap;

endmodule

// ===== rtl/oriented_rect_overlap_test_unit.sv =====
`timescale 1ns / 1ps
// oriented rectangle overlap test, 2d separating axis form
// input stream: one request per box pair; tdata holds ten signed q16.8 fields,
//   left edge a x/y, left edge b x/y, right edge a x/y, right edge b x/y,
//   center difference x/y, 24 bits each from bit 0 up (240 bits, no padding)
// output stream: one result per request; tdata bit 0 overlap, bits 3:1 index of
//   the first separating axis (0..3, 4 when the boxes overlap), bits 7:4 zero
// pipeline: a request accepted at the input passes through, in order,
//   the input register, product stage, magnitude stage and compare/output register
// throughput: one request per cycle while results are taken; the pipeline has four
//   stages, and all 28 coordinate products are formed in parallel in the product stage
// stall: each stage advances only when the next one is empty or advancing, so
//   a held result backs the pipe up stage by stage; bubbles are squeezed out
//   and requests keep being taken until every stage is full
// reset: synchronous, active low; clears every stage valid bit, so no result
//   is shown; no request is taken while reset is held, and the input accepts
//   right after reset is released
`include "oriented_rect_overlap_test_unit_defines.svh"

module oriented_rect_overlap_test_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // fields from bit 0: left_edge_a_x, left_edge_a_y, left_edge_b_x,
    // left_edge_b_y, right_edge_a_x, right_edge_a_y, right_edge_b_x,
    // right_edge_b_y, center_diff_x, center_diff_y
    input  logic [ortest_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // fields from bit 0: overlap, separating_axis, then zero fill
    output logic [ortest_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int N_STAGES = 4;

    // stage valids: 0 input reg, 1 products, 2 magnitudes, 3 result
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] n_vld;
    logic [N_STAGES-1:0] stage_en;

    ortest_pkg::t_item  r_item;
    ortest_pkg::t_prods prods;
    ortest_pkg::t_mags  mags;
    logic               overlap;
    ortest_pkg::t_axis  axis;

    // a stage may load when it is empty or its content moves on this cycle
    always_comb begin
        stage_en[N_STAGES-1] = ~r_vld[N_STAGES-1] | i_m_axis_tready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = ~r_vld[k] | stage_en[k+1];
        end
        n_vld[0] = stage_en[0] ? i_s_axis_tvalid : r_vld[0];
        for (int k = 1; k < N_STAGES; k++) begin
            n_vld[k] = stage_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // field packing in tdata matches the item struct layout bit for bit
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_item <= ortest_pkg::t_item'(i_s_axis_tdata[ortest_pkg::IN_FIELDS_W-1:0]);
        end
    end

    ortest_mul u_mul (
        .i_clk   (i_clk),
        .i_en    (stage_en[1]),
        .i_item  (r_item),
        .o_prods (prods)
    );

    ortest_abs u_abs (
        .i_clk   (i_clk),
        .i_en    (stage_en[2]),
        .i_prods (prods),
        .o_mags  (mags)
    );

    ortest_cmp u_cmp (
        .i_clk     (i_clk),
        .i_en      (stage_en[3]),
        .i_mags    (mags),
        .o_overlap (overlap),
        .o_axis    (axis)
    );

    // nothing is taken while reset is held
    assign o_s_axis_tready = stage_en[0] & i_rst_n;
    assign o_m_axis_tvalid = r_vld[N_STAGES-1];
    assign o_m_axis_tdata  = {{(ortest_pkg::OUT_DATA_W - ortest_pkg::OUT_FIELDS_W){1'b0}},
                              axis, overlap};

    // result fields agree with each other
    `ORTEST_ASSERT_IMP(a_result_coherent, o_m_axis_tvalid, (overlap == (axis == ortest_pkg::AXIS_NONE)) && (axis <= ortest_pkg::AXIS_NONE), "overlap flag and axis index disagree")
    // a full pipe with a stalled receiver takes no request
    `ORTEST_ASSERT_IMP(a_full_no_accept, (&r_vld) && !i_m_axis_tready, !o_s_axis_tready, "request accepted into a full pipeline")
    // an item in the input register is never dropped on its way down
    `ORTEST_ASSERT_NXT(a_stage0_moves, r_vld[0] && stage_en[1], r_vld[1], "item lost between input and product stage")
    // a stalled result stays put inside the block
    `ORTEST_ASSERT_NXT(a_result_held, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(axis) && $stable(overlap), "held result changed")

endmodule
